[rtl/core/assert_macros.svh]
// ----------------------------------------------------------------------------
// assert_macros.svh
// assertion macros used by the checker file
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// pre holds at an edge, post holds at the next edge
`define ASSERT_NEXT(label, clk, rst, pre, post) \
   label: assert property (@(posedge clk) disable iff (rst) (pre) |=> (post)) \
      else $error("assertion failed: next-cycle check");

// pre holds at an edge, post holds at the same edge
`define ASSERT_SAME(label, clk, rst, pre, post) \
   label: assert property (@(posedge clk) disable iff (rst) (pre) |-> (post)) \
      else $error("assertion failed: same-cycle check");

`endif

[rtl/core/pse_pkg.sv]
// ----------------------------------------------------------------------------
// pse_pkg
// shared constants, codes and types of the postfix stack evaluator
// ----------------------------------------------------------------------------
package pse_pkg;

   localparam int STACK_DEPTH = 128;
   localparam int DATA_W      = 32;
   localparam int FUNC_W      = 3;
   localparam int OPND_W      = 31;
   localparam int ADDR_W      = $clog2(STACK_DEPTH);
   localparam int CNT_W       = $clog2(STACK_DEPTH + 1);
   localparam int DIV_CNT_W   = $clog2(DATA_W);

   localparam logic [FUNC_W-1:0] FUNC_OPERAND = 3'd0;
   localparam logic [FUNC_W-1:0] FUNC_ADD     = 3'd1;
   localparam logic [FUNC_W-1:0] FUNC_SUB     = 3'd2;
   localparam logic [FUNC_W-1:0] FUNC_MUL     = 3'd3;
   localparam logic [FUNC_W-1:0] FUNC_DIV     = 3'd4;

   typedef enum logic [3:0] {
      S_IDLE,
      S_POP_B,
      S_WAIT_A,
      S_POP_A,
      S_EXEC,
      S_DIV,
      S_PUSH,
      S_WAIT_F,
      S_FINAL
   } state_type;

   typedef struct packed {
      logic              start;
      logic [DATA_W-1:0] dividend;
      logic [DATA_W-1:0] divisor;
   } div_req_type;

   typedef struct packed {
      logic              done;
      logic [DATA_W-1:0] quotient;
   } div_rsp_type;

endpackage

[rtl/core/pse_divider.sv]
// ----------------------------------------------------------------------------
// pse_divider
// iterative signed divider, one quotient bit per cycle, truncates toward zero
// ----------------------------------------------------------------------------
module pse_divider
   import pse_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  div_req_type div_req,
   output div_rsp_type div_rsp
);

   logic                 busy_ff, busy_in;
   logic                 done_ff, done_in;
   logic                 neg_ff, neg_in;
   logic [DIV_CNT_W-1:0] cnt_ff, cnt_in;
   logic [DATA_W-1:0]    rem_ff, rem_in;
   logic [DATA_W-1:0]    quo_ff, quo_in;
   logic [DATA_W-1:0]    dvs_ff, dvs_in;
   logic [DATA_W-1:0]    abs_a, abs_b;
   logic [DATA_W:0]      shifted;
   logic [DATA_W:0]      diff;

   assign abs_a   = div_req.dividend[DATA_W-1] ? (~div_req.dividend + DATA_W'(1))
                                               : div_req.dividend;
   assign abs_b   = div_req.divisor[DATA_W-1] ? (~div_req.divisor + DATA_W'(1))
                                              : div_req.divisor;
   assign shifted = {rem_ff, quo_ff[DATA_W-1]};
   assign diff    = shifted - {1'b0, dvs_ff};

   always_comb begin
      busy_in = busy_ff;
      done_in = 1'b0;
      neg_in  = neg_ff;
      cnt_in  = cnt_ff;
      rem_in  = rem_ff;
      quo_in  = quo_ff;
      dvs_in  = dvs_ff;
      if (div_req.start) begin
         busy_in = 1'b1;
         neg_in  = div_req.dividend[DATA_W-1] ^ div_req.divisor[DATA_W-1];
         cnt_in  = '0;
         rem_in  = '0;
         quo_in  = abs_a;
         dvs_in  = abs_b;
      end else if (busy_ff) begin
         if (!diff[DATA_W]) begin
            rem_in = diff[DATA_W-1:0];
            quo_in = {quo_ff[DATA_W-2:0], 1'b1};
         end else begin
            rem_in = shifted[DATA_W-1:0];
            quo_in = {quo_ff[DATA_W-2:0], 1'b0};
         end
         cnt_in = cnt_ff + DIV_CNT_W'(1);
         if (cnt_ff == DIV_CNT_W'(DATA_W - 1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
      neg_ff <= neg_in;
      cnt_ff <= cnt_in;
      rem_ff <= rem_in;
      quo_ff <= quo_in;
      dvs_ff <= dvs_in;
   end

   assign div_rsp.done     = done_ff;
   assign div_rsp.quotient = neg_ff ? (~quo_ff + DATA_W'(1)) : quo_ff;

endmodule

[rtl/core/postfix_stack_evaluator.sv]
// ----------------------------------------------------------------------------
// postfix_stack_evaluator
// evaluates a postfix expression, one token word per input handshake
// operand: pushed as is; add, subtract, multiply: pop b, pop a, execute, push
// other symbol: pops b and a, pushes nothing; divide: runs the 32-step divider
// between execute and push; by zero: pushes 0 and sets the flag; last token: pops
// and loads the result word, waiting while the result port stays stalled
// reset: empty stack, clear flags, no result pending
// ----------------------------------------------------------------------------
module postfix_stack_evaluator
   import pse_pkg::*;
(
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     req_valid,
   output logic                     req_stall,
   input  logic [FUNC_W-1:0]        req_func,
   input  logic [OPND_W-1:0]        req_operand,
   input  logic                     req_last,
   output logic                     rsp_valid,
   input  logic                     rsp_stall,
   output logic signed [DATA_W-1:0] rsp_value,
   output logic                     rsp_divide_by_zero,
   output logic                     rsp_underflow,
   output logic                     rsp_overflow
);

   state_type state_ff, state_in;

   logic [FUNC_W-1:0] func_ff, func_in;
   logic              last_ff, last_in;
   logic [CNT_W-1:0]  count_ff, count_in;
   logic              div0_ff, div0_in;
   logic              under_ff, under_in;
   logic              over_ff, over_in;
   logic [DATA_W-1:0] a_ff, a_in;
   logic [DATA_W-1:0] b_ff, b_in;
   logic [DATA_W-1:0] push_ff, push_in;
   logic [DATA_W-1:0] rd_ff;
   logic              rsp_valid_ff, rsp_valid_in;
   logic [DATA_W-1:0] rsp_value_ff, rsp_value_in;
   logic              rsp_div0_ff, rsp_div0_in;
   logic              rsp_under_ff, rsp_under_in;
   logic              rsp_over_ff, rsp_over_in;

   logic [DATA_W-1:0] mem [STACK_DEPTH];
   logic              mem_we;
   logic [CNT_W-1:0]  cnt_m1;
   logic [ADDR_W-1:0] rd_addr;
   logic              empty;
   logic              full;
   logic              accept;
   logic              rsp_free;
   logic [DATA_W-1:0] product;

   div_req_type div_req;
   div_rsp_type div_rsp;

   pse_divider u_divider (
      .clock   (clock),
      .reset   (reset),
      .div_req (div_req),
      .div_rsp (div_rsp)
   );

   assign cnt_m1   = count_ff - CNT_W'(1);
   assign rd_addr  = cnt_m1[ADDR_W-1:0];
   assign empty    = (count_ff == '0);
   assign full     = (count_ff >= CNT_W'(STACK_DEPTH));
   assign accept   = (state_ff == S_IDLE) && req_valid;
   assign rsp_free = !rsp_valid_ff || !rsp_stall;
   assign product  = a_ff * b_ff;

   // next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         S_IDLE: begin
            if (req_valid) begin
               state_in = (req_func == FUNC_OPERAND) ? S_PUSH : S_POP_B;
            end
         end
         S_POP_B:  state_in = S_WAIT_A;
         S_WAIT_A: state_in = S_POP_A;
         S_POP_A:  state_in = S_EXEC;
         S_EXEC: begin
            priority if (func_ff == FUNC_ADD || func_ff == FUNC_SUB ||
                         func_ff == FUNC_MUL) begin
               state_in = S_PUSH;
            end else if (func_ff == FUNC_DIV) begin
               state_in = (b_ff == '0) ? S_PUSH : S_DIV;
            end else begin
               state_in = last_ff ? S_FINAL : S_IDLE;
            end
         end
         S_DIV: begin
            if (div_rsp.done) begin
               state_in = S_PUSH;
            end
         end
         S_PUSH:   state_in = last_ff ? S_WAIT_F : S_IDLE;
         S_WAIT_F: state_in = S_FINAL;
         S_FINAL: begin
            if (rsp_free) begin
               state_in = S_IDLE;
            end
         end
         default:  state_in = S_IDLE;
      endcase
   end

   // datapath controls
   always_comb begin
      func_in          = func_ff;
      last_in          = last_ff;
      count_in         = count_ff;
      div0_in          = div0_ff;
      under_in         = under_ff;
      over_in          = over_ff;
      a_in             = a_ff;
      b_in             = b_ff;
      push_in          = push_ff;
      mem_we           = 1'b0;
      div_req.start    = 1'b0;
      div_req.dividend = a_ff;
      div_req.divisor  = b_ff;
      rsp_valid_in     = rsp_valid_ff && rsp_stall;
      rsp_value_in     = rsp_value_ff;
      rsp_div0_in      = rsp_div0_ff;
      rsp_under_in     = rsp_under_ff;
      rsp_over_in      = rsp_over_ff;
      unique case (state_ff)
         S_IDLE: begin
            if (req_valid) begin
               func_in = req_func;
               last_in = req_last;
               push_in = {1'b0, req_operand};
            end
         end
         S_POP_B: begin
            if (empty) begin
               b_in     = '0;
               under_in = 1'b1;
            end else begin
               b_in     = rd_ff;
               count_in = cnt_m1;
            end
         end
         S_POP_A: begin
            if (empty) begin
               a_in     = '0;
               under_in = 1'b1;
            end else begin
               a_in     = rd_ff;
               count_in = cnt_m1;
            end
         end
         S_EXEC: begin
            priority if (func_ff == FUNC_ADD) begin
               push_in = a_ff + b_ff;
            end else if (func_ff == FUNC_SUB) begin
               push_in = a_ff - b_ff;
            end else if (func_ff == FUNC_MUL) begin
               push_in = product;
            end else if (func_ff == FUNC_DIV) begin
               if (b_ff == '0) begin
                  push_in = '0;
                  div0_in = 1'b1;
               end else begin
                  div_req.start = 1'b1;
               end
            end else begin
               push_in = push_ff;
            end
         end
         S_DIV: begin
            if (div_rsp.done) begin
               push_in = div_rsp.quotient;
            end
         end
         S_PUSH: begin
            if (full) begin
               over_in = 1'b1;
            end else begin
               mem_we   = 1'b1;
               count_in = count_ff + CNT_W'(1);
            end
         end
         S_FINAL: begin
            if (rsp_free) begin
               rsp_valid_in = 1'b1;
               rsp_value_in = empty ? '0 : rd_ff;
               rsp_div0_in  = div0_ff;
               rsp_under_in = under_ff | empty;
               rsp_over_in  = over_ff;
               count_in     = '0;
               div0_in      = 1'b0;
               under_in     = 1'b0;
               over_in      = 1'b0;
            end
         end
         default: begin
            count_in = count_ff;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         count_ff     <= '0;
         div0_ff      <= 1'b0;
         under_ff     <= 1'b0;
         over_ff      <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         count_ff     <= count_in;
         div0_ff      <= div0_in;
         under_ff     <= under_in;
         over_ff      <= over_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      func_ff      <= func_in;
      last_ff      <= last_in;
      a_ff         <= a_in;
      b_ff         <= b_in;
      push_ff      <= push_in;
      rsp_value_ff <= rsp_value_in;
      rsp_div0_ff  <= rsp_div0_in;
      rsp_under_ff <= rsp_under_in;
      rsp_over_ff  <= rsp_over_in;
   end

   // stack memory, top entry read every cycle
   always_ff @(posedge clock) begin
      if (mem_we) begin
         mem[count_ff[ADDR_W-1:0]] <= push_ff;
      end
      rd_ff <= mem[rd_addr];
   end

   assign req_stall          = !accept && (state_ff != S_IDLE);
   assign rsp_valid          = rsp_valid_ff;
   assign rsp_value          = rsp_value_ff;
   assign rsp_divide_by_zero = rsp_div0_ff;
   assign rsp_underflow      = rsp_under_ff;
   assign rsp_overflow       = rsp_over_ff;

endmodule

[rtl/core/pse_checker.sv]
// ----------------------------------------------------------------------------
// pse_checker
// port-level checks of the postfix stack evaluator, bound to the top level
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module pse_checker
   import pse_pkg::*;
(
   input logic                     clock,
   input logic                     reset,
   input logic                     req_valid,
   input logic                     req_stall,
   input logic [FUNC_W-1:0]        req_func,
   input logic [OPND_W-1:0]        req_operand,
   input logic                     req_last,
   input logic                     rsp_valid,
   input logic                     rsp_stall,
   input logic signed [DATA_W-1:0] rsp_value,
   input logic                     rsp_divide_by_zero,
   input logic                     rsp_underflow,
   input logic                     rsp_overflow
);

   logic req_accept;

   assign req_accept = req_valid && !req_stall;

   // a token word keeps the block busy for at least the next cycle
   `ASSERT_NEXT(busy_after_accept, clock, reset, req_accept, req_stall)

   // a result word never appears in the cycle right after a token word
   `ASSERT_NEXT(no_result_after_accept, clock, reset, req_accept, !$rose(rsp_valid))

   // a stalled token word stays up and keeps its fields
   `ASSERT_NEXT(req_holds_word, clock, reset, req_valid && req_stall,
                req_valid && $stable({req_func, req_operand, req_last}))

   // a pending result word stays up while stalled
   `ASSERT_NEXT(rsp_holds_valid, clock, reset, rsp_valid && rsp_stall, rsp_valid)

   // a stalled result word keeps its value and flags
   `ASSERT_NEXT(rsp_holds_value, clock, reset, rsp_valid && rsp_stall,
                $stable({rsp_value, rsp_divide_by_zero, rsp_underflow, rsp_overflow}))

endmodule

bind postfix_stack_evaluator pse_checker u_checker (.*);

[verif/postfix_stack_evaluator_tb.sv]
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// postfix_stack_evaluator_tb
// drives token words into the evaluator and checks every result word
// against a local stack calculator; directed corner expressions come first,
// then random well-formed expressions mixed with noise, stack-filling runs,
// bursty sending and a patterned, sometimes long, receiver stall
// ----------------------------------------------------------------------------
module postfix_stack_evaluator_tb;
   import pse_pkg::*;

   localparam logic [FUNC_W-1:0] FUNC_OTHER = 3'd5;
   localparam logic [FUNC_W-1:0] FUNC_RSVD6 = 3'd6;
   localparam logic [FUNC_W-1:0] FUNC_RSVD7 = 3'd7;
   localparam logic [OPND_W-1:0] OPND_MAX   = {OPND_W{1'b1}};
   localparam logic [DATA_W-1:0] INT_MIN    = {1'b1, {(DATA_W-1){1'b0}}};
   localparam logic [DATA_W-1:0] MINUS_ONE  = {DATA_W{1'b1}};
   localparam int CYCLE_LIMIT  = 500000;
   localparam int RANDOM_ITEMS = 700;
   localparam int DRAIN_CYCLES = 60;
   localparam int LONG_HOLD    = 600;

   typedef struct {
      logic [FUNC_W-1:0] func;
      logic [OPND_W-1:0] operand;
      logic              last;
   } token_word_type;

   typedef struct {
      logic signed [DATA_W-1:0] value;
      logic                     div0;
      logic                     under;
      logic                     over;
   } result_word_type;

   logic                     clock = 1'b0;
   logic                     reset = 1'b1;
   logic                     req_valid = 1'b0;
   logic                     req_stall;
   logic [FUNC_W-1:0]        req_func = '0;
   logic [OPND_W-1:0]        req_operand = '0;
   logic                     req_last = 1'b0;
   logic                     rsp_valid;
   logic                     rsp_stall = 1'b0;
   logic signed [DATA_W-1:0] rsp_value;
   logic                     rsp_divide_by_zero;
   logic                     rsp_underflow;
   logic                     rsp_overflow;

   token_word_type  token_q[$];
   result_word_type result_q[$];
   int              tokens_total = 0;
   int              tokens_accepted = 0;
   int              error_count = 0;
   int              cycle_count = 0;

   // calculator state
   logic [DATA_W-1:0] calc_stack [0:STACK_DEPTH-1];
   int                calc_depth = 0;
   logic              calc_div0 = 1'b0;
   logic              calc_under = 1'b0;
   logic              calc_over = 1'b0;

   postfix_stack_evaluator dut (
      .clock              (clock),
      .reset              (reset),
      .req_valid          (req_valid),
      .req_stall          (req_stall),
      .req_func           (req_func),
      .req_operand        (req_operand),
      .req_last           (req_last),
      .rsp_valid          (rsp_valid),
      .rsp_stall          (rsp_stall),
      .rsp_value          (rsp_value),
      .rsp_divide_by_zero (rsp_divide_by_zero),
      .rsp_underflow      (rsp_underflow),
      .rsp_overflow       (rsp_overflow)
   );

   always #4 clock = ~clock;

   function automatic void calc_push(logic [DATA_W-1:0] v);
      if (calc_depth < STACK_DEPTH) begin
         calc_stack[calc_depth] = v;
         calc_depth++;
      end else begin
         calc_over = 1'b1;
      end
   endfunction

   function automatic logic [DATA_W-1:0] calc_pop();
      if (calc_depth == 0) begin
         calc_under = 1'b1;
         return '0;
      end
      calc_depth--;
      return calc_stack[calc_depth];
   endfunction

   function automatic void calc_token(token_word_type t);
      logic [DATA_W-1:0] a;
      logic [DATA_W-1:0] b;
      result_word_type   r;
      if (t.func == FUNC_OPERAND) begin
         calc_push({1'b0, t.operand});
      end else begin
         b = calc_pop();
         a = calc_pop();
         case (t.func)
            FUNC_ADD: calc_push(a + b);
            FUNC_SUB: calc_push(a - b);
            FUNC_MUL: calc_push(a * b);
            FUNC_DIV: begin
               if (b == '0) begin
                  calc_div0 = 1'b1;
                  calc_push('0);
               end else if (a == INT_MIN && b == MINUS_ONE) begin
                  calc_push(INT_MIN);
               end else begin
                  calc_push($signed(a) / $signed(b));
               end
            end
            default: ;
         endcase
      end
      if (t.last) begin
         r.value = calc_pop();
         r.div0  = calc_div0;
         r.under = calc_under;
         r.over  = calc_over;
         result_q.push_back(r);
         calc_depth = 0;
         calc_div0  = 1'b0;
         calc_under = 1'b0;
         calc_over  = 1'b0;
      end
   endfunction

   // stimulus building
   function automatic logic [OPND_W-1:0] rand_operand();
      case ($urandom_range(0, 7))
         0: return '0;
         1: return OPND_W'($urandom_range(1, 15));
         2: return OPND_MAX - OPND_W'($urandom_range(0, 3));
         default: return OPND_W'($urandom);
      endcase
   endfunction

   function automatic void add_token(logic [FUNC_W-1:0] f, logic [OPND_W-1:0] v, logic l);
      token_word_type t;
      t.func    = f;
      t.operand = v;
      t.last    = l;
      token_q.push_back(t);
   endfunction

   function automatic logic [FUNC_W-1:0] rand_operator();
      if ($urandom_range(0, 15) == 0) return FUNC_OTHER;
      return FUNC_W'($urandom_range(FUNC_ADD, FUNC_DIV));
   endfunction

   // random expression that keeps at least two entries before each operator while no other symbol is drawn
   function automatic void add_wellformed();
      int n;
      int depth;
      depth = 0;
      n = $urandom_range(1, 16);
      for (int i = 0; i < n; i++) begin
         if (depth < 2 || $urandom_range(0, 2) == 0) begin
            add_token(FUNC_OPERAND, rand_operand(), 1'b0);
            depth++;
         end else begin
            add_token(rand_operator(), rand_operand(), 1'b0);
            depth--;
         end
      end
      while (depth > 1) begin
         add_token(FUNC_W'($urandom_range(FUNC_ADD, FUNC_DIV)), rand_operand(), 1'b0);
         depth--;
      end
      if (depth == 0) add_token(FUNC_OPERAND, rand_operand(), 1'b0);
      token_q[$].last = 1'b1;
   endfunction

   function automatic void add_noise();
      int n;
      n = $urandom_range(1, 6);
      for (int i = 0; i < n; i++)
         add_token(FUNC_W'($urandom_range(0, 7)), rand_operand(), i == n - 1);
   endfunction

   // fills the stack past its depth
   function automatic void add_stack_fill();
      int n;
      n = STACK_DEPTH + $urandom_range(1, 3);
      for (int i = 0; i < n; i++)
         add_token(FUNC_OPERAND, rand_operand(), 1'b0);
      for (int i = 0; i < 3; i++)
         add_token(FUNC_W'($urandom_range(FUNC_ADD, FUNC_DIV)), rand_operand(), 1'b0);
      add_token(FUNC_ADD, rand_operand(), 1'b1);
   endfunction

   // driver
   int burst_left = 0;
   int gap_left = 0;

   always @(posedge clock) begin
      token_word_type t;
      if (reset) begin
         req_valid <= 1'b0;
      end else begin
         if (req_valid && !req_stall) begin
            t.func    = req_func;
            t.operand = req_operand;
            t.last    = req_last;
            calc_token(t);
            tokens_accepted++;
         end
         if (!(req_valid && req_stall)) begin
            if (gap_left > 0) begin
               gap_left--;
               req_valid <= 1'b0;
            end else if (token_q.size() > 0) begin
               t = token_q.pop_front();
               req_valid   <= 1'b1;
               req_func    <= t.func;
               req_operand <= t.operand;
               req_last    <= t.last;
               if (burst_left == 0) begin
                  burst_left = $urandom_range(1, 24);
                  gap_left = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 10);
               end else begin
                  burst_left--;
               end
            end else begin
               req_valid <= 1'b0;
            end
         end
      end
   end

   // receiver stall pattern
   int stall_mode = 0;
   int mode_left = 0;
   int hold_left = 0;
   int seen_results = 0;
   bit hold_done = 1'b0;

   always @(posedge clock) begin
      if (reset) begin
         rsp_stall <= 1'b0;
      end else begin
         if (rsp_valid && !rsp_stall) seen_results++;
         if (!hold_done && seen_results >= 10) begin
            hold_done = 1'b1;
            hold_left = LONG_HOLD;
         end
         if (mode_left == 0) begin
            stall_mode = $urandom_range(0, 3);
            mode_left = $urandom_range(50, 200);
         end else begin
            mode_left--;
         end
         if (hold_left > 0) begin
            hold_left--;
            rsp_stall <= 1'b1;
         end else begin
            case (stall_mode)
               0: rsp_stall <= 1'b0;
               1: rsp_stall <= ($urandom_range(0, 3) == 0);
               2: rsp_stall <= ($urandom_range(0, 3) != 0);
               default: rsp_stall <= ~rsp_stall;
            endcase
         end
      end
   end

   // monitor
   always @(posedge clock) begin
      result_word_type r;
      if (!reset && rsp_valid && !rsp_stall) begin
         if (result_q.size() == 0) begin
            $error("result word with none expected: value %0d", rsp_value);
            error_count++;
         end else begin
            r = result_q.pop_front();
            if (rsp_value !== r.value) begin
               $error("value mismatch: expected %0d, got %0d", r.value, rsp_value);
               error_count++;
            end
            if (rsp_divide_by_zero !== r.div0) begin
               $error("divide_by_zero mismatch: expected %0b, got %0b",
                      r.div0, rsp_divide_by_zero);
               error_count++;
            end
            if (rsp_underflow !== r.under) begin
               $error("underflow mismatch: expected %0b, got %0b", r.under, rsp_underflow);
               error_count++;
            end
            if (rsp_overflow !== r.over) begin
               $error("overflow mismatch: expected %0b, got %0b", r.over, rsp_overflow);
               error_count++;
            end
         end
      end
   end

   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("postfix_stack_evaluator regression: fail");
         $finish;
      end
   end

   initial begin
      bit fill_done;
      int pick;
      fill_done = 1'b0;

      // largest operand, last on an operand
      add_token(FUNC_OPERAND, OPND_MAX, 1'b1);
      // most negative divided by minus one
      add_token(FUNC_OPERAND, '0, 1'b0);
      add_token(FUNC_OPERAND, OPND_MAX, 1'b0);
      add_token(FUNC_SUB, '0, 1'b0);
      add_token(FUNC_OPERAND, 31'd1, 1'b0);
      add_token(FUNC_SUB, '0, 1'b0);
      add_token(FUNC_OPERAND, '0, 1'b0);
      add_token(FUNC_OPERAND, 31'd1, 1'b0);
      add_token(FUNC_SUB, '0, 1'b0);
      add_token(FUNC_DIV, OPND_MAX, 1'b1);
      // add and multiply wrap
      add_token(FUNC_OPERAND, OPND_MAX, 1'b0);
      add_token(FUNC_OPERAND, OPND_MAX, 1'b0);
      add_token(FUNC_ADD, '0, 1'b0);
      add_token(FUNC_OPERAND, 31'd3, 1'b0);
      add_token(FUNC_MUL, '0, 1'b1);
      // divide by zero
      add_token(FUNC_OPERAND, 31'd5, 1'b0);
      add_token(FUNC_OPERAND, '0, 1'b0);
      add_token(FUNC_DIV, '0, 1'b1);
      // other symbol on an empty stack
      add_token(FUNC_OTHER, OPND_MAX, 1'b1);
      // unused codes, then underflow on the final pop
      add_token(FUNC_OPERAND, 31'd4, 1'b0);
      add_token(FUNC_OPERAND, 31'd9, 1'b0);
      add_token(FUNC_RSVD6, '0, 1'b0);
      add_token(FUNC_OPERAND, 31'd3, 1'b0);
      add_token(FUNC_RSVD7, '0, 1'b1);

      add_stack_fill();
      while (token_q.size() < RANDOM_ITEMS + 24) begin
         pick = $urandom_range(0, 99);
         if (pick < 75) add_wellformed();
         else if (pick < 90) add_noise();
         else add_token(FUNC_W'($urandom_range(0, 7)), rand_operand(), 1'b1);
         if (!fill_done && token_q.size() > 450) begin
            add_stack_fill();
            fill_done = 1'b1;
         end
      end
      tokens_total = token_q.size();

      repeat (5) @(posedge clock);
      reset <= 1'b0;

      while (tokens_accepted < tokens_total) @(posedge clock);
      while (result_q.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);

      if (error_count == 0) begin
         $display("postfix_stack_evaluator regression: pass");
      end else begin
         $display("postfix_stack_evaluator regression: fail");
      end
      $finish;
   end

endmodule
